FILE: src/calendar_date_step_core_macros.svh
// Assertion macros shared by the calendar date step RTL.
`ifndef CALENDAR_DATE_STEP_CORE_MACROS_SVH
`define CALENDAR_DATE_STEP_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define CDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent starting in the cycle after its antecedent.
`define CDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cds_pkg.sv
// Types, constants and month-length helper for the calendar date step core.
`default_nettype none

package cds_pkg;

    // Month codes
    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    // Day codes and lengths
    localparam logic [4:0] DAY_FIRST = 5'd1;
    localparam logic [4:0] LEN_31    = 5'd31;
    localparam logic [4:0] LEN_30    = 5'd30;
    localparam logic [4:0] LEN_29    = 5'd29;
    localparam logic [4:0] LEN_28    = 5'd28;

    // Year replacing a negative request
    localparam logic [14:0] YEAR_DEFAULT = 15'd2000;

    // Divisibility by 25 on 15 bits: y*inverse mod 2^15 stays at or below the bound
    localparam logic [14:0] INV25     = 15'h5C29;
    localparam logic [14:0] Q25_BOUND = 15'd1310;

    // Flag bit positions
    localparam int FLAG_YEAR  = 0;
    localparam int FLAG_MONTH = 1;
    localparam int FLAG_DAY   = 2;

    typedef struct packed {
        logic        [5:0]  in_day;
        logic        [3:0]  in_month;
        logic signed [15:0] in_year;
    } req_t;

    typedef struct packed {
        logic        [4:0]  cur_day;
        logic        [3:0]  cur_month;
        logic        [14:0] cur_year;
        logic        [2:0]  fix_flags;
        logic        [4:0]  fwd_day;
        logic        [3:0]  fwd_month;
        logic        [15:0] fwd_year;
        logic        [4:0]  prev_day;
        logic        [3:0]  prev_month;
        logic signed [15:0] prev_year;
    } rsp_t;

    // Corrected date with month lengths, passed to the roll stage
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [14:0] year;
        logic [2:0]  flags;
        logic [4:0]  len;
        logic [4:0]  prev_len;
    } fix_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] res;
        case (m) inside
            MON_APR, MON_JUN, MON_SEP, MON_NOV: res = LEN_30;
            MON_FEB: res = leap ? LEN_29 : LEN_28;
            default: res = LEN_31;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: src/cds_fix.sv
// Two-stage date correction: year and month fix, then leap test and day fix.
`default_nettype none

module cds_fix (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire cds_pkg::req_t req,
    output logic               vld,
    output cds_pkg::fix_t      fixed
);
    import cds_pkg::*;

    typedef struct packed {
        logic [5:0]  day;
        logic [3:0]  month;
        logic [14:0] year;
        logic [14:0] prod;
        logic [1:0]  flags;
    } s1_t;

    logic  v1_reg;
    s1_t   s1_reg, s1_next;
    logic  v2_reg;
    fix_t  s2_reg, s2_next;

    logic [29:0] prod_full;
    logic        div4, div16, div25, leap;
    logic [3:0]  prev_m;
    logic [4:0]  len;
    logic        day_bad;

    // Replace a negative year and an unknown month, start the divide-by-25 test
    always_comb
    begin
        s1_next = '0;
        s1_next.day = req.in_day;
        if (req.in_year[15])
        begin
            s1_next.year = YEAR_DEFAULT;
            s1_next.flags[FLAG_YEAR] = 1'b1;
        end
        else
        begin
            s1_next.year = req.in_year[14:0];
        end
        if ((req.in_month < MON_JAN) || (req.in_month > MON_DEC))
        begin
            s1_next.month = MON_JAN;
            s1_next.flags[FLAG_MONTH] = 1'b1;
        end
        else
        begin
            s1_next.month = req.in_month;
        end
        prod_full = {15'd0, s1_next.year} * {15'd0, INV25};
        s1_next.prod = prod_full[14:0];
    end

    // Decide the leap year, month lengths and the day fix
    always_comb
    begin
        div4  = (s1_reg.year[1:0] == 2'd0);
        div16 = (s1_reg.year[3:0] == 4'd0);
        div25 = (s1_reg.prod <= Q25_BOUND);
        leap  = div4 && (!div25 || div16);
        len   = month_len(s1_reg.month, leap);
        prev_m = (s1_reg.month == MON_JAN) ? MON_DEC : (s1_reg.month - 4'd1);
        day_bad = (s1_reg.day == 6'd0) || (s1_reg.day > {1'b0, len});

        s2_next = '0;
        s2_next.month = s1_reg.month;
        s2_next.year  = s1_reg.year;
        s2_next.flags = {day_bad, s1_reg.flags};
        s2_next.day   = day_bad ? DAY_FIRST : s1_reg.day[4:0];
        s2_next.len   = len;
        s2_next.prev_len = month_len(prev_m, leap);
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    // Hold the payload of each stage
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    assign vld   = v2_reg;
    assign fixed = s2_reg;

endmodule

`default_nettype wire

FILE: src/cds_roll.sv
// Final stage: form the following and preceding dates and register the result beat.
`default_nettype none

module cds_roll (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire cds_pkg::fix_t fixed,
    output logic               done,
    output cds_pkg::rsp_t      rsp
);
    import cds_pkg::*;

    logic done_reg;
    rsp_t rsp_reg, rsp_next;

    // Roll forward and back across month and year ends
    always_comb
    begin
        rsp_next = '0;
        rsp_next.cur_day   = fixed.day;
        rsp_next.cur_month = fixed.month;
        rsp_next.cur_year  = fixed.year;
        rsp_next.fix_flags = fixed.flags;

        rsp_next.fwd_month = fixed.month;
        rsp_next.fwd_year  = {1'b0, fixed.year};
        if (fixed.day == fixed.len)
        begin
            rsp_next.fwd_day = DAY_FIRST;
            if (fixed.month == MON_DEC)
            begin
                rsp_next.fwd_month = MON_JAN;
                rsp_next.fwd_year  = {1'b0, fixed.year} + 16'd1;
            end
            else
            begin
                rsp_next.fwd_month = fixed.month + 4'd1;
            end
        end
        else
        begin
            rsp_next.fwd_day = fixed.day + 5'd1;
        end

        rsp_next.prev_month = fixed.month;
        rsp_next.prev_year  = {1'b0, fixed.year};
        if (fixed.day == DAY_FIRST)
        begin
            if (fixed.month == MON_JAN)
            begin
                rsp_next.prev_day   = LEN_31;
                rsp_next.prev_month = MON_DEC;
                rsp_next.prev_year  = {1'b0, fixed.year} - 16'd1;
            end
            else
            begin
                rsp_next.prev_day   = fixed.prev_len;
                rsp_next.prev_month = fixed.month - 4'd1;
            end
        end
        else
        begin
            rsp_next.prev_day = fixed.day - 5'd1;
        end
    end

    // Advance the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= load;
        end
    end

    // Hold the result beat
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

FILE: src/calendar_date_step_core.sv
// Top level of the calendar date step core: correction pipeline and roll stage.
`default_nettype none

// Takes one date per clock and returns its corrected form with the following
// and preceding dates as a one-cycle beat marked by done, once it has passed
// through the three register stages: year and month fix with the divide-by-25
// multiply, then leap test, month lengths and day fix, then the forward and
// backward roll. Every stage moves on every clock, so busy is always low and
// the receiver must take each beat in the cycle it is shown.
`include "calendar_date_step_core_macros.svh"

module calendar_date_step_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire cds_pkg::req_t req,
    output logic               done,
    output cds_pkg::rsp_t      rsp
);
    import cds_pkg::*;

    logic vld;
    fix_t fixed;

    // Accept a beat on every clock
    assign busy = 1'b0;

    cds_fix u_fix (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .vld   (vld),
        .fixed (fixed)
    );

    cds_roll u_roll (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (vld),
        .fixed (fixed),
        .done  (done),
        .rsp   (rsp)
    );

    `CDS_ASSERT_NEXT(a_latency, clk, rst_n, start && !busy, ##2 done,
        "accepted beat did not give a result three cycles later")
    `CDS_ASSERT_NOW(a_cur_range, clk, rst_n, done,
        (rsp.cur_day != 5'd0) && (rsp.cur_month >= MON_JAN) && (rsp.cur_month <= MON_DEC),
        "corrected date out of range")
    `CDS_ASSERT_NOW(a_fwd_day, clk, rst_n, done,
        (rsp.fwd_day == DAY_FIRST) || (rsp.fwd_day == rsp.cur_day + 5'd1),
        "following day neither first nor successor")
    `CDS_ASSERT_NOW(a_prev_year, clk, rst_n, done,
        (rsp.prev_year == $signed({1'b0, rsp.cur_year}))
            || (rsp.prev_month == MON_DEC && rsp.prev_day == LEN_31),
        "preceding year changed outside a year rollback")

endmodule

`default_nettype wire
